@@ hdl/multi_channel_software_timer_core_macros.svh @@
// ----------------------------------------------------------------------------
// multi_channel_software_timer_core_macros
// Assertion macros for the software timer core.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SOFTWARE_TIMER_CORE_MACROS_SVH
`define MULTI_CHANNEL_SOFTWARE_TIMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MST_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MST_ASSERT(label, clk, rst, prop)
`define MST_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ hdl/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and codes of the software timer core.
// ----------------------------------------------------------------------------
package mst_pkg;
  localparam int DefChannels = 16;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic div_start;  // start the period divider
    logic scan_clear; // reset the slot pointer
    logic scan_next;  // advance the slot pointer
    logic tick_slot;  // apply the tick to the current slot
    logic search;     // compare the current slot for create or lookup
    logic apply_cmd;  // commit the command to the found slot
  } mst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic found;
    logic [2:0] action;
  } mst_stat_t;
endpackage

@@ hdl/mst_datapath.sv @@
// ----------------------------------------------------------------------------
// mst_datapath
// Channel table, period divider and result register.
// ----------------------------------------------------------------------------
`include "multi_channel_software_timer_core_macros.svh"
module mst_datapath import mst_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  input  logic [2:0]  action,
  input  logic [15:0] chan_id,
  input  logic [23:0] period_us,
  input  logic [15:0] repeat_count,
  input  mst_cmd_t    cmd,
  output mst_stat_t   stat,
  output logic        done,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [15:0] result_id,
  output logic        last
);
  localparam int SW = $clog2(CHANNELS);

  logic [23:0] tick_len;
  logic [2:0]  act;
  logic [15:0] id_q;
  logic [15:0] rep_q;
  logic [15:0] next_id;

  logic [CHANNELS-1:0] used, deleted, forever_r, stopped;
  logic [15:0] sid [CHANNELS];
  logic [23:0] per [CHANNELS];
  logic [23:0] left [CHANNELS];
  logic [15:0] reps [CHANNELS];

  logic [SW-1:0] ptr;
  logic          found;
  logic [SW-1:0] fslot;

  // Restoring divider, one quotient bit per cycle.
  logic [23:0] dq, dd;
  logic [24:0] drem;
  logic [4:0]  dcnt;
  logic        dbusy, ddone;
  logic [24:0] dtrial;

  assign dtrial = {drem[23:0], dq[23]} - {1'b0, dd};
  assign stat = '{div_done: ddone, scan_last: (ptr == SW'(CHANNELS-1)),
                  found: found, action: act};

  logic [23:0] lm1;
  assign lm1 = left[ptr] - 24'd1;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    ddone <= 1'b0;
    if (rst) begin
      tick_len <= 24'd1000;
      next_id <= 16'd1;
      used <= '0;
      deleted <= '0;
      forever_r <= '0;
      stopped <= '1;
      dbusy <= 1'b0;
      found <= 1'b0;
      ptr <= '0;
      act <= ACT_TICK;
    end else begin
      if (cfg_we) tick_len <= cfg_data;
      if (cmd.load) begin
        act <= action;
        id_q <= chan_id;
        rep_q <= repeat_count;
        dq <= period_us;
        found <= 1'b0;
      end
      if (cmd.div_start) begin
        dd <= (tick_len == 24'd0) ? 24'd1 : tick_len;
        drem <= '0;
        dcnt <= 5'd24;
        dbusy <= 1'b1;
      end else if (dbusy) begin
        if (!dtrial[24]) begin
          drem <= dtrial;
          dq <= {dq[22:0], 1'b1};
        end else begin
          drem <= {drem[23:0], dq[23]};
          dq <= {dq[22:0], 1'b0};
        end
        dcnt <= dcnt - 5'd1;
        if (dcnt == 5'd1) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
      if (cmd.scan_clear) ptr <= '0;
      else if (cmd.scan_next) ptr <= ptr + SW'(1);

      if (cmd.search && !found) begin
        if (act == ACT_CREATE ? !used[ptr] : (used[ptr] && sid[ptr] == id_q)) begin
          found <= 1'b1;
          fslot <= ptr;
        end
      end

      if (cmd.tick_slot && used[ptr]) begin
        if (deleted[ptr]) begin
          used[ptr] <= 1'b0;
          deleted[ptr] <= 1'b0;
          forever_r[ptr] <= 1'b0;
          stopped[ptr] <= 1'b1;
        end else if (!stopped[ptr] && left[ptr] != 24'd0) begin
          if (lm1 == 24'd0) begin
            done <= 1'b1;
            kind <= KIND_EXPIRY;
            status <= ST_OK;
            result_id <= sid[ptr];
            last <= 1'b0;
            if (!forever_r[ptr]) begin
              if (reps[ptr] <= 16'd1) begin
                stopped[ptr] <= 1'b1;
                reps[ptr] <= 16'd0;
              end else reps[ptr] <= reps[ptr] - 16'd1;
            end
            left[ptr] <= per[ptr];
          end else left[ptr] <= lm1;
        end
      end

      if (cmd.apply_cmd) begin
        done <= 1'b1;
        kind <= (act == ACT_TICK) ? KIND_DONE : KIND_ACK;
        status <= ST_OK;
        result_id <= '0;
        last <= 1'b1;
        case (act)
          ACT_TICK: ;
          ACT_CREATE: begin
            if (!found) status <= ST_FULL;
            else begin
              used[fslot] <= 1'b1;
              deleted[fslot] <= 1'b0;
              forever_r[fslot] <= 1'b0;
              stopped[fslot] <= 1'b1;
              sid[fslot] <= next_id;
              per[fslot] <= dq;
              left[fslot] <= dq;
              reps[fslot] <= '0;
              result_id <= next_id;
              next_id <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
            end
          end
          default: begin
            if (!found) status <= ST_NOTFOUND;
            else if (act == ACT_START) begin
              left[fslot] <= per[fslot];
              forever_r[fslot] <= (rep_q == 16'd0);
              reps[fslot] <= rep_q;
              stopped[fslot] <= 1'b0;
            end else if (act == ACT_STOP) stopped[fslot] <= 1'b1;
            else deleted[fslot] <= 1'b1;
          end
        endcase
      end
    end
  end

  `MST_ASSERT(a_id_nonzero, clk, rst, next_id != 16'd0)
  `MST_ASSERT(a_del_used, clk, rst, (deleted & ~used) == '0)
  `MST_ASSERT(a_div_done, clk, rst, ddone |-> !dbusy)
endmodule

@@ hdl/mst_ctrl.sv @@
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer for commands and ticks.
// ----------------------------------------------------------------------------
`include "multi_channel_software_timer_core_macros.svh"
module mst_ctrl import mst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [2:0] action,
  input  mst_stat_t stat,
  output mst_cmd_t  cmd,
  output logic      busy
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_ACK  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_clear = 1'b1;
          if (action <= ACT_DELETE) state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.action == ACT_TICK) state_next = S_TICK;
        else if (stat.action == ACT_CREATE) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else state_next = S_SRCH;
      end
      S_TICK: begin
        cmd.tick_slot = 1'b1;
        cmd.scan_next = 1'b1;
        if (stat.scan_last) state_next = S_ACK;
      end
      S_DIV: begin
        // The free-slot search runs alongside the divider; a table longer
        // than the divide finishes its search afterwards.
        cmd.search = 1'b1;
        if (!stat.scan_last) cmd.scan_next = 1'b1;
        if (stat.div_done) state_next = stat.scan_last ? S_ACK : S_SRCH;
      end
      S_SRCH: begin
        cmd.search = 1'b1;
        cmd.scan_next = 1'b1;
        if (stat.scan_last) state_next = S_ACK;
      end
      S_ACK: begin
        cmd.apply_cmd = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `MST_ASSERT(a_ack_idle, clk, rst, (state == S_ACK) |=> (state == S_IDLE))
  `MST_ASSERT_RST(a_rst_idle, clk, rst |=> (state == S_IDLE))
  `MST_ASSERT(a_dec_loaded, clk, rst, (state == S_DEC) |-> $past(cmd.load))
endmodule

@@ hdl/multi_channel_software_timer_core.sv @@
// ----------------------------------------------------------------------------
// multi_channel_software_timer_core
// Table of periodic timer channels driven by commands and ticks.
// ----------------------------------------------------------------------------
// Channel   Signals                                  Direction
// input     start, busy, action, chan_id, ...        item in
// result    done, kind, status, result_id, last      item out
// config    cfg_we, cfg_data                         register write
//
// A tick steps through every slot in the table scan.
// A create runs the 24-step restoring divider alongside the free-slot
// search, and finishes the search afterwards when it outlasts the divide.
// Start, stop and delete search the table for the id.
// Reset is synchronous; all slots come out free and stopped.
// Results appear for one cycle on done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module multi_channel_software_timer_core import mst_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [15:0] chan_id,
  input  logic [23:0] period_us,
  input  logic [15:0] repeat_count,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  output logic        done,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [15:0] result_id,
  output logic        last
);
  mst_cmd_t  cmd;
  mst_stat_t stat;

  // The controller sequences each item; the datapath holds the table.
  mst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  mst_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .action(action), .chan_id(chan_id), .period_us(period_us),
    .repeat_count(repeat_count), .cmd(cmd), .stat(stat), .done(done),
    .kind(kind), .status(status), .result_id(result_id), .last(last)
  );
endmodule
